// ===== rtl/core/psitp_pkg.sv =====
// Package for the PSI section transport stream packetizer.
// Holds the packet constants, the CRC-32/MPEG-2 byte table and the queue entry type.
// Depends on nothing.
`default_nettype none

package psitp_pkg;

   // Transport packet layout.
   localparam int unsigned PACKET_BYTES = 188;
   localparam int unsigned PID_WIDTH    = 13;
   localparam int unsigned CRC_UNITS    = 4;
   localparam int unsigned QUEUE_DEPTH  = 4;

   // Header and fill byte values.
   localparam logic [7:0] SYNC_MARK    = 8'h47;
   localparam logic [7:0] PUSI_FLAG    = 8'h40;
   localparam logic [7:0] PAYLOAD_ONLY = 8'h10;
   localparam logic [7:0] STUFF_BYTE   = 8'hFF;
   localparam logic [7:0] POINTER_BYTE = 8'h00;

   // CRC-32/MPEG-2 parameters.
   localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   typedef logic [31:0] crc_table_type [256];

   // Builds the MSB-first byte table at elaboration.
   function automatic crc_table_type build_crc_table();
      crc_table_type tbl;
      logic [31:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = {i[7:0], 24'h000000};
         for (int b = 0; b < 8; b++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
         end
         tbl[i] = c;
      end
      return tbl;
   endfunction

   localparam crc_table_type CRC_TABLE = build_crc_table();

   // One classified section byte as it travels from front to back.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [31:0] crc;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/psi_section_ts_packetizer.sv =====
// Top level of the PSI section to transport stream packetizer.
// Depends on psitp_pkg, psitp_front, psitp_queue and psitp_back.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  section_byte[7:0], last_byte
//   rsp_      out        rsp_valid/rsp_stall  out_byte[7:0], repeat_count[7:0],
//                                             packet_end, section_end
//   csr_      in         csr_wr_en            csr_wr_data[12:0] (stream PID)
//
// The sequencer fetches each queued byte in ST_IDLE and then emits its results one at a time,
// so an ordinary payload byte gives one result; a packet start adds 4 or 5 header bytes
// and the last byte adds 4 CRC bytes and at most one stuffing transaction.
// The front end accepts a byte every cycle while the queue has room.
// Reset is synchronous; no clearing pass follows.
// A stalled result stays in the output register while the queue keeps filling.
`default_nettype none

module psi_section_ts_packetizer #(
   parameter int unsigned QUEUE_DEPTH = psitp_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [psitp_pkg::PID_WIDTH-1:0]     csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_section_byte,
   input  wire logic                                req_last_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [7:0]                               rsp_out_byte,
   output logic [7:0]                               rsp_repeat_count,
   output logic                                     rsp_packet_end,
   output logic                                     rsp_section_end
);
   import psitp_pkg::*;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   logic [PID_WIDTH-1:0] pid_ff;
   logic                 q_push, q_full, q_pop, q_empty;
   entry_type            push_entry, pop_entry;
   logic [ENTRY_W-1:0]   pop_bits;

   // Stream PID register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= '0;
      end else if (csr_wr_en) begin
         pid_ff <= csr_wr_data;
      end
   end

   psitp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_section_byte (req_section_byte),
      .req_last_byte    (req_last_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   psitp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_bits),
      .empty     (q_empty)
   );

   assign pop_entry = entry_type'(pop_bits);

   psitp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .stream_pid       (pid_ff),
      .q_empty          (q_empty),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_section_end  (rsp_section_end)
   );

endmodule

`default_nettype wire

// ===== rtl/core/psitp_front.sv =====
// Front end of the packetizer: accepts section bytes, runs the CRC and classifies the last byte.
// Depends on psitp_pkg; feeds the entry queue.
`default_nettype none

module psitp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_section_byte,
   input  wire logic                req_last_byte,
   input  wire logic                q_full,
   output logic                     q_push,
   output psitp_pkg::entry_type     q_entry
);
   import psitp_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic        started_ff, started_in;
   logic [31:0] crc_next;
   logic        eff_last;
   logic        accept;

   // A transaction is taken whenever the queue has room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Byte-wise table CRC step; a last mark on the opening byte is ignored.
   always_comb begin
      crc_next = {crc_ff[23:0], 8'h00} ^ CRC_TABLE[crc_ff[31:24] ^ req_section_byte];
      eff_last = req_last_byte && started_ff;
      q_push   = accept;
      q_entry  = '{data: req_section_byte, last: eff_last, crc: crc_next};
      crc_in     = crc_ff;
      started_in = started_ff;
      if (accept) begin
         crc_in     = eff_last ? CRC_INIT : crc_next;
         started_in = !eff_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= CRC_INIT;
         started_ff <= 1'b0;
      end else begin
         crc_ff     <= crc_in;
         started_ff <= started_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/psitp_queue.sv =====
// Small register queue that decouples the front end from the packet sequencer.
// Depends on nothing; width and depth come from the parent.
`default_nettype none

module psitp_queue #(
   parameter int unsigned WIDTH = 41,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/psitp_back.sv =====
// Packet sequencer: expands queued entries into headers, payload, CRC bytes and stuffing.
// Depends on psitp_pkg; reads the entry queue and drives the result register.
`default_nettype none

module psitp_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [psitp_pkg::PID_WIDTH-1:0]     stream_pid,
   input  wire logic                                q_empty,
   input  wire psitp_pkg::entry_type                q_entry,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [7:0]                               rsp_out_byte,
   output logic [7:0]                               rsp_repeat_count,
   output logic                                     rsp_packet_end,
   output logic                                     rsp_section_end
);
   import psitp_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HDR0  = 8'b0000_0010,
      ST_HDR1  = 8'b0000_0100,
      ST_HDR2  = 8'b0000_1000,
      ST_HDR3  = 8'b0001_0000,
      ST_PTR   = 8'b0010_0000,
      ST_DATA  = 8'b0100_0000,
      ST_STUFF = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   entry_type   entry_ff, entry_in;
   logic [2:0]  unit_ff, unit_in;
   logic [7:0]  pos_ff, pos_in;
   logic [3:0]  cc_ff, cc_in;
   logic        first_ff, first_in;

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  rep_ff, rep_in;
   logic        pend_ff, pend_in;
   logic        send_ff, send_in;

   logic        out_free;
   logic        emit;
   logic [7:0]  e_byte, e_rep, unit_byte, pos_inc;
   logic        e_pend, e_send, pkt_full;

   assign out_free = !valid_ff || !rsp_stall;

   // Byte carried by the current unit: the section byte, then the CRC MSB first.
   always_comb begin
      case (unit_ff)
         3'd0:    unit_byte = entry_ff.data;
         3'd1:    unit_byte = entry_ff.crc[31:24];
         3'd2:    unit_byte = entry_ff.crc[23:16];
         3'd3:    unit_byte = entry_ff.crc[15:8];
         3'd4:    unit_byte = entry_ff.crc[7:0];
         default: unit_byte = entry_ff.crc[7:0];
      endcase
   end

   // Sequencer: one result per cycle while the register is free, but none in ST_IDLE.
   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      unit_in  = unit_ff;
      pos_in   = pos_ff;
      cc_in    = cc_ff;
      first_in = first_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      e_byte   = unit_byte;
      e_rep    = 8'd1;
      e_pend   = 1'b0;
      e_send   = 1'b0;
      pos_inc  = pos_ff + 8'd1;
      pkt_full = (pos_inc == 8'(PACKET_BYTES));
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               entry_in = q_entry;
               unit_in  = '0;
               state_in = (pos_ff == 8'd0) ? ST_HDR0 : ST_DATA;
            end
         end
         ST_HDR0: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = SYNC_MARK;
               pos_in   = pos_inc;
               state_in = ST_HDR1;
            end
         end
         ST_HDR1: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = (first_ff ? PUSI_FLAG : 8'h00) | {3'b000, stream_pid[12:8]};
               pos_in   = pos_inc;
               state_in = ST_HDR2;
            end
         end
         ST_HDR2: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = stream_pid[7:0];
               pos_in   = pos_inc;
               state_in = ST_HDR3;
            end
         end
         ST_HDR3: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = PAYLOAD_ONLY | {4'h0, cc_ff};
               pos_in   = pos_inc;
               cc_in    = cc_ff + 4'd1;
               state_in = first_ff ? ST_PTR : ST_DATA;
            end
         end
         ST_PTR: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = POINTER_BYTE;
               pos_in   = pos_inc;
               first_in = 1'b0;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = unit_byte;
               e_pend = pkt_full;
               pos_in = pkt_full ? 8'd0 : pos_inc;
               if (!entry_ff.last) begin
                  state_in = ST_IDLE;
               end else if (unit_ff == 3'(CRC_UNITS)) begin
                  // CRC done: close the section here if the packet is exactly full.
                  if (pkt_full) begin
                     e_send   = 1'b1;
                     cc_in    = '0;
                     first_in = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_STUFF;
                  end
               end else begin
                  unit_in  = unit_ff + 3'd1;
                  state_in = pkt_full ? ST_HDR0 : ST_DATA;
               end
            end
         end
         ST_STUFF: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = STUFF_BYTE;
               e_rep    = 8'(PACKET_BYTES) - pos_ff;
               e_pend   = 1'b1;
               e_send   = 1'b1;
               pos_in   = '0;
               cc_in    = '0;
               first_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: loads on emit, drains when the transaction is taken.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      rep_in   = rep_ff;
      pend_in  = pend_ff;
      send_in  = send_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = e_byte;
         rep_in   = e_rep;
         pend_in  = e_pend;
         send_in  = e_send;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         unit_ff  <= '0;
         pos_ff   <= '0;
         cc_ff    <= '0;
         first_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
         pos_ff   <= pos_in;
         cc_ff    <= cc_in;
         first_ff <= first_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      byte_ff  <= byte_in;
      rep_ff   <= rep_in;
      pend_ff  <= pend_in;
      send_ff  <= send_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_repeat_count = rep_ff;
   assign rsp_packet_end   = pend_ff;
   assign rsp_section_end  = send_ff;

endmodule

`default_nettype wire

// ===== dv/psitp_checker.sv =====
// Scoreboard for the PSI section transport stream packetizer.
// Watches the csr_, req_ and rsp_ ports, predicts the packet bytes and compares them.
// Depends on psitp_pkg for the packet constants and the CRC polynomial.
`default_nettype none

module psitp_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [psitp_pkg::PID_WIDTH-1:0] csr_wr_data,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [7:0]                      req_section_byte,
   input  wire logic                            req_last_byte,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [7:0]                      rsp_out_byte,
   input  wire logic [7:0]                      rsp_repeat_count,
   input  wire logic                            rsp_packet_end,
   input  wire logic                            rsp_section_end,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   result_count
);

   import psitp_pkg::*;

   // One expected output transaction.
   typedef struct {
      logic [7:0] data;
      logic [7:0] reps;
      logic       pend;
      logic       send;
   } ts_byte_type;

   ts_byte_type          ts_bytes[$];
   logic [PID_WIDTH-1:0] pid;
   logic [31:0]          crc_acc;
   int unsigned          pkt_pos;
   logic [3:0]           cont_cnt;
   logic                 first_pkt;
   logic                 in_section;
   int                   errors;
   int                   seen;

   function automatic void push_ts_byte(logic [7:0] data, logic [7:0] reps, logic pend);
      ts_byte_type e;
      e.data = data;
      e.reps = reps;
      e.pend = pend;
      e.send = 1'b0;
      ts_bytes.push_back(e);
   endfunction

   // MSB-first CRC-32/MPEG-2 update, one bit at a time.
   function automatic logic [31:0] crc_after(logic [31:0] c, logic [7:0] data);
      logic [31:0] r;
      r = c ^ {data, 24'h000000};
      for (int b = 0; b < 8; b++) begin
         r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
      end
      return r;
   endfunction

   // Places one payload byte, opening a packet with its header when needed.
   function automatic void place_byte(logic [7:0] data);
      if (pkt_pos == 0) begin
         push_ts_byte(SYNC_MARK, 8'd1, 1'b0);
         push_ts_byte((first_pkt ? PUSI_FLAG : 8'h00) | {3'b000, pid[12:8]}, 8'd1, 1'b0);
         push_ts_byte(pid[7:0], 8'd1, 1'b0);
         push_ts_byte(PAYLOAD_ONLY | {4'h0, cont_cnt}, 8'd1, 1'b0);
         pkt_pos = 4;
         if (first_pkt) begin
            push_ts_byte(POINTER_BYTE, 8'd1, 1'b0);
            pkt_pos   = 5;
            first_pkt = 1'b0;
         end
         cont_cnt = cont_cnt + 4'd1;
      end
      pkt_pos++;
      if (pkt_pos >= PACKET_BYTES) begin
         push_ts_byte(data, 8'd1, 1'b1);
         pkt_pos = 0;
      end else begin
         push_ts_byte(data, 8'd1, 1'b0);
      end
   endfunction

   function automatic void restart_section();
      crc_acc    = CRC_INIT;
      pkt_pos    = 0;
      cont_cnt   = 4'd0;
      first_pkt  = 1'b1;
      in_section = 1'b0;
   endfunction

   // Expected output for one accepted section byte.
   function automatic void predict_section_byte(logic [7:0] data, logic last);
      logic        closing;
      logic [31:0] crc_out;
      // A last mark on the opening byte of a section is ignored.
      closing    = last && in_section;
      in_section = 1'b1;
      crc_acc    = crc_after(crc_acc, data);
      place_byte(data);
      if (closing) begin
         crc_out = crc_acc;
         for (int k = 3; k >= 0; k--) begin
            place_byte(crc_out[8*k +: 8]);
         end
         if (pkt_pos != 0) begin
            push_ts_byte(STUFF_BYTE, 8'(PACKET_BYTES - pkt_pos), 1'b1);
         end
         ts_bytes[ts_bytes.size()-1].send = 1'b1;
         restart_section();
      end
   endfunction

   // Result checks come before prediction: a result never stems from an item
   // accepted at the same edge.
   always @(posedge clock) begin : watch
      ts_byte_type want;
      if (reset) begin
         ts_bytes.delete();
         pid    = '0;
         errors = 0;
         seen   = 0;
         restart_section();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (ts_bytes.size() == 0) begin
               if (errors < 10) begin
                  $display("Unexpected output transaction %0d: byte %02h x%0d pend %0b send %0b",
                           seen, rsp_out_byte, rsp_repeat_count, rsp_packet_end,
                           rsp_section_end);
               end
               errors++;
            end else begin
               want = ts_bytes.pop_front();
               if (rsp_out_byte !== want.data || rsp_repeat_count !== want.reps ||
                   rsp_packet_end !== want.pend || rsp_section_end !== want.send) begin
                  if (errors < 10) begin
                     $write("Mismatch on output transaction %0d: expected byte %02h x%0d ",
                            seen, want.data, want.reps);
                     $write("pend %0b send %0b, ", want.pend, want.send);
                     $display("got byte %02h x%0d pend %0b send %0b",
                              rsp_out_byte, rsp_repeat_count, rsp_packet_end,
                              rsp_section_end);
                  end
                  errors++;
               end
            end
         end
         if (csr_wr_en) begin
            pid = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            predict_section_byte(req_section_byte, req_last_byte);
         end
      end
      fail_count   <= errors;
      pending      <= ts_bytes.size();
      result_count <= seen;
   end

endmodule

`default_nettype wire

// ===== dv/tb_psi_section_ts_packetizer.sv =====
// Testbench top for the PSI section transport stream packetizer.
// Drives sections and PID writes, stalls the output, and reports the verdict.
// Depends on psitp_pkg, the packetizer RTL and psitp_checker.
`default_nettype none

module tb_psi_section_ts_packetizer;

   import psitp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned IDLE_TAIL    = 16;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned RANDOM_ITEMS = 30;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_kind_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 csr_wr_en        = 1'b0;
   logic [PID_WIDTH-1:0] csr_wr_data      = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_section_byte = 8'h00;
   logic                 req_last_byte    = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic [7:0]           rsp_repeat_count;
   logic                 rsp_packet_end;
   logic                 rsp_section_end;

   int          fail_count;
   int          pending;
   int          result_count;
   int          items_sent;
   int          sections_sent;
   int          pid_writes;
   int          burst_left;
   bit          want_hold;
   int unsigned cycle_count;

   psi_section_ts_packetizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_section_byte (req_section_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_section_end  (rsp_section_end)
   );

   psitp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_section_byte (req_section_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_section_end  (rsp_section_end),
      .fail_count       (fail_count),
      .pending          (pending),
      .result_count     (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stall pattern: one long hold-off on request, otherwise random modes.
   int         hold_left;
   int         mode_left;
   bit         hold_done;
   logic [1:0] stall_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         mode_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= (hold_left != 0);
      end else if (want_hold && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = 2'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 120);
         end
         mode_left--;
         case (stall_mode)
            2'd0: begin
               rsp_stall <= 1'b0;
            end
            2'd1: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
               rsp_stall <= ($urandom_range(0, 7) == 0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   // Run limit in case the block hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run limit of %0d cycles reached with %0d results pending", CYCLE_LIMIT,
               pending);
      $display("FAIL psi_section_ts_packetizer");
      $finish;
   end

   // Offers one section byte and holds it until the transaction completes.
   // The sender works in bursts with random gaps between them.
   task automatic send_item(logic [7:0] data, logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_section_byte <= data;
      req_last_byte    <= last;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
   endtask

   // Sends count bytes; close marks the final one, mark_first puts a stray mark on the first.
   task automatic send_bytes(int count, fill_kind_type fill, bit mark_first, bit close);
      logic [7:0] data;
      logic       last;
      for (int i = 0; i < count; i++) begin
         case (fill)
            FILL_ZERO: data = 8'h00;
            FILL_ONES: data = 8'hFF;
            default:   data = 8'($urandom_range(0, 255));
         endcase
         last = (close && i == count - 1) || (mark_first && i == 0);
         send_item(data, last);
      end
      if (close) begin
         sections_sent++;
      end
   endtask

   // Waits until every expected result has been taken, then a short tail.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_pid(logic [PID_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pid_writes++;
   endtask

   initial begin
      int            start_items;
      int            len;
      fill_kind_type fill;
      logic [PID_WIDTH-1:0] pid_value;

      items_sent    = 0;
      sections_sent = 0;
      pid_writes    = 0;
      burst_left    = 0;
      want_hold     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Short sections at the field extremes, with stray and honored last marks.
      write_pid('1);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      sections_sent++;
      send_bytes(3, FILL_ONES, 1'b1, 1'b1);
      send_item(8'hA5, 1'b1);
      send_item(8'h5A, 1'b1);
      sections_sent++;
      wait_idle();
      write_pid('0);
      send_bytes(4, FILL_ZERO, 1'b0, 1'b1);
      send_bytes(6, FILL_RANDOM, 1'b0, 1'b1);
      wait_idle();
      write_pid(13'h0AAA);
      send_bytes(5, FILL_RANDOM, 1'b1, 1'b1);

      // A section length that puts the last CRC byte exactly on the packet boundary,
      // so no stuffing follows; the receiver holds off while it streams in.
      want_hold = 1'b1;
      send_bytes(179, FILL_RANDOM, 1'b0, 1'b1);

      // Random short sections, with PID changes between some of them.
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            case ($urandom_range(0, 3))
               0:       pid_value = '0;
               1:       pid_value = '1;
               default: pid_value = PID_WIDTH'($urandom_range(0, 8191));
            endcase
            write_pid(pid_value);
         end
         len  = $urandom_range(2, 24);
         fill = ($urandom_range(0, 7) == 0) ? fill_kind_type'($urandom_range(1, 2))
                                            : FILL_RANDOM;
         send_bytes(len, fill, $urandom_range(0, 4) == 0, 1'b1);
      end
      wait_idle();

      $display("Sent %0d section bytes in %0d sections over %0d PID settings,",
               items_sent, sections_sent, pid_writes + 1);
      $display("with one long output hold-off; %0d output transactions checked.",
               result_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS psi_section_ts_packetizer");
      end else begin
         $display("%0d mismatches, %0d results still pending", fail_count, pending);
         $display("FAIL psi_section_ts_packetizer");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/psitp_pkg.sv
rtl/core/psitp_front.sv
rtl/core/psitp_queue.sv
rtl/core/psitp_back.sv
rtl/core/psi_section_ts_packetizer.sv
dv/psitp_checker.sv
dv/tb_psi_section_ts_packetizer.sv
